// File: hw/rtl/cfq_pkg.sv
// ----------------------------------------------------------------------------
// cfq_pkg
// Shared types and constants for the circular FIFO queue unit.
// ----------------------------------------------------------------------------
package cfq_pkg;

  localparam int unsigned DepthDef     = 16;
  localparam int unsigned DataWidthDef = 32;

  localparam int unsigned ReqW    = 2;
  localparam int unsigned WordW   = 32;
  localparam int unsigned EntryW  = 5;
  localparam int unsigned StatusW = 2;

  // Request kinds.
  localparam logic [ReqW-1:0] REQ_INSERT  = 2'd0;
  localparam logic [ReqW-1:0] REQ_DELETE  = 2'd1;
  localparam logic [ReqW-1:0] REQ_DISPLAY = 2'd2;
  localparam logic [ReqW-1:0] REQ_SIZE    = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_FULL  = 2'd1;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd2;

  // Result queue depth and its count width.
  localparam int unsigned OutqDepth = 4;
  localparam int unsigned OutqAw    = $clog2(OutqDepth);
  localparam int unsigned OutqCw    = $clog2(OutqDepth + 1);

  typedef struct packed {
    logic [ReqW-1:0]  req_type;
    logic [WordW-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [WordW-1:0]   data_word;
    logic [EntryW-1:0]  entry_count;
    logic [StatusW-1:0] status;
    logic               last_flag;
  } res_t;

endpackage

// File: hw/rtl/cfq_front.sv
// ----------------------------------------------------------------------------
// cfq_front
// Request intake: a two-entry command queue between the ports and the back end.
// ----------------------------------------------------------------------------
module cfq_front import cfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  output logic full_o,
  input  cmd_t cmd_i,
  output logic cmd_valid_o,
  output cmd_t cmd_o,
  input  logic cmd_pop_i
);

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = slot_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// File: hw/rtl/cfq_back.sv
// ----------------------------------------------------------------------------
// cfq_back
// Executes queued requests against the ring store and issues result items.
// ----------------------------------------------------------------------------
module cfq_back import cfq_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  cmd_t              cmd_i,
  output logic              cmd_pop_o,
  input  logic [OutqCw-1:0] outq_cnt_i,
  output logic              res_valid_o,
  output res_t              res_o
);

  localparam int unsigned Aw = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned Cw = $clog2(DEPTH + 1);
  localparam logic [Aw-1:0] LastSlot = Aw'(DEPTH - 1);
  localparam logic [Cw-1:0] FullCnt  = Cw'(DEPTH);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_q;

  logic [Aw-1:0] head_q, head_d, tail_q, tail_d;
  logic [Cw-1:0] cnt_q, cnt_d;
  logic          disp_q, disp_d;
  logic [Aw-1:0] dslot_q, dslot_d;
  logic [Cw-1:0] dleft_q, dleft_d;

  logic               s_valid_q, s_mem_q;
  logic [Cw-1:0]      s_cnt_q;
  logic [StatusW-1:0] s_status_q;
  logic               s_last_q;

  logic               issue;
  logic               rd_en, wr_en;
  logic [Aw-1:0]      rd_addr;
  logic               r_mem, r_last;
  logic [Cw-1:0]      r_cnt;
  logic [StatusW-1:0] r_status;
  logic [Aw-1:0]      cur_slot;
  logic [Cw-1:0]      cur_left;
  logic [63:0]        wr_ext, rd_ext;

  function automatic logic [Aw-1:0] next_slot(input logic [Aw-1:0] s);
    return (s == LastSlot) ? '0 : s + Aw'(1);
  endfunction

  // Keep one spare place in the result queue for the item in the read stage.
  assign issue = cmd_valid_i &&
                 ((OutqCw + 1)'(outq_cnt_i) + (OutqCw + 1)'(s_valid_q) <
                  (OutqCw + 1)'(OutqDepth));

  assign cur_slot = disp_q ? dslot_q : head_q;
  assign cur_left = disp_q ? dleft_q : cnt_q;
  assign wr_ext   = 64'(signed'(cmd_i.value));

  always_comb begin
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    disp_d    = disp_q;
    dslot_d   = dslot_q;
    dleft_d   = dleft_q;
    cmd_pop_o = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    rd_addr   = head_q;
    r_mem     = 1'b0;
    r_last    = 1'b1;
    r_cnt     = cnt_q;
    r_status  = ST_OK;
    if (issue) begin
      case (cmd_i.req_type)
        REQ_INSERT: begin
          cmd_pop_o = 1'b1;
          if (cnt_q >= FullCnt) begin
            r_status = ST_FULL;
          end else begin
            wr_en  = 1'b1;
            tail_d = next_slot(tail_q);
            cnt_d  = cnt_q + Cw'(1);
            r_cnt  = cnt_d;
          end
        end
        REQ_DELETE: begin
          cmd_pop_o = 1'b1;
          if (cnt_q == '0) begin
            r_status = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_q;
            r_mem   = 1'b1;
            head_d  = next_slot(head_q);
            cnt_d   = cnt_q - Cw'(1);
            r_cnt   = cnt_d;
          end
        end
        REQ_DISPLAY: begin
          if (cnt_q == '0) begin
            cmd_pop_o = 1'b1;
            r_status  = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cur_slot;
            r_mem   = 1'b1;
            r_last  = (cur_left == Cw'(1));
            if (r_last) begin
              cmd_pop_o = 1'b1;
              disp_d    = 1'b0;
            end else begin
              disp_d  = 1'b1;
              dslot_d = next_slot(cur_slot);
              dleft_d = cur_left - Cw'(1);
            end
          end
        end
        default: begin
          cmd_pop_o = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= '0;
      cnt_q      <= '0;
      disp_q     <= 1'b0;
      dslot_q    <= '0;
      dleft_q    <= '0;
      s_valid_q  <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      cnt_q      <= cnt_d;
      disp_q     <= disp_d;
      dslot_q    <= dslot_d;
      dleft_q    <= dleft_d;
      s_valid_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    s_mem_q    <= r_mem;
    s_cnt_q    <= r_cnt;
    s_status_q <= r_status;
    s_last_q   <= r_last;
  end

  // Ring store: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[tail_q] <= wr_ext[DATA_WIDTH-1:0];
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  assign rd_ext = 64'(signed'(rd_q));

  assign res_valid_o       = s_valid_q;
  assign res_o.data_word   = s_mem_q ? rd_ext[WordW-1:0] : '0;
  assign res_o.entry_count = EntryW'(s_cnt_q);
  assign res_o.status      = s_status_q;
  assign res_o.last_flag   = s_last_q;

endmodule

// File: hw/rtl/cfq_outq.sv
// ----------------------------------------------------------------------------
// cfq_outq
// Result queue that decouples the back end from the consumer.
// ----------------------------------------------------------------------------
module cfq_outq import cfq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  input  res_t              res_i,
  output logic [OutqCw-1:0] cnt_o,
  output logic              empty_o,
  input  logic              pop_i,
  output res_t              res_o
);

  res_t              slot_q [OutqDepth];
  logic [OutqAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [OutqCw-1:0] cnt_q;
  logic              do_pop;

  assign empty_o = (cnt_q == '0);
  assign cnt_o   = cnt_q;
  assign res_o   = slot_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  // The back end never pushes without a free place, so no full check here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (res_valid_i) begin
        wr_ptr_q <= wr_ptr_q + OutqAw'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + OutqAw'(1);
      end
      cnt_q <= cnt_q + OutqCw'(res_valid_i) - OutqCw'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      slot_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

// File: hw/rtl/circular_fifo_queue_unit.sv
// Path: command queue, back end read stage, result queue, each registered.
// Throughput: insert, delete and size, one per cycle; display, one entry per
// cycle, set by the single read port; all while the result queue has room.
// Reset: asynchronous, active low; pointers, counts and both queues clear,
// the ring store keeps its contents and needs no clearing pass.
// ----------------------------------------------------------------------------
// circular_fifo_queue_unit
// Ring-buffer FIFO of signed words driven by insert, delete, display and size
// requests, with queue-style request and result ports.
// ----------------------------------------------------------------------------
module circular_fifo_queue_unit import cfq_pkg::*; #(
  parameter int unsigned DEPTH      = DepthDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request side: a transfer happens when push is high and full is low.
  input  logic               push,
  output logic               full,
  input  logic [ReqW-1:0]    req_type_i,
  input  logic [WordW-1:0]   push_value_i,
  // Result side: a transfer happens when pop is high and empty is low.
  output logic               empty,
  input  logic               pop,
  output logic [WordW-1:0]   data_word_o,
  output logic [EntryW-1:0]  entry_count_o,
  output logic [StatusW-1:0] status_o,
  output logic               last_flag_o
);

  cmd_t              cmd_in, cmd;
  logic              cmd_valid, cmd_pop;
  logic              res_valid;
  res_t              res, res_head;
  logic [OutqCw-1:0] outq_cnt;

  assign cmd_in.req_type = req_type_i;
  assign cmd_in.value    = push_value_i;

  // The front end only buffers requests, so a request transfer never waits
  // on the back end unless two requests are already pending.
  cfq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .cmd_i       (cmd_in),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // The back end owns the ring store and its head, tail and count. A display
  // request stays at the head of the command queue until its last entry has
  // been issued.
  cfq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .outq_cnt_i  (outq_cnt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Results wait here, so a stalled consumer only stops the back end once
  // the queue has no free place left.
  cfq_outq u_outq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .cnt_o       (outq_cnt),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_head)
  );

  assign data_word_o   = res_head.data_word;
  assign entry_count_o = res_head.entry_count;
  assign status_o      = res_head.status;
  assign last_flag_o   = res_head.last_flag;

endmodule
